### src/segc_pkg.sv
`timescale 1ns / 1ps

package segc_pkg;

  // Default coordinate width: signed Q16.16 fixed point
  localparam int DEF_COORD_WIDTH = 32;

  // Bits of operand b consumed by one multiplier stage
  localparam int MUL_DIGIT = 16;

endpackage

### src/segc_query_if.sv
`timescale 1ns / 1ps

interface segc_query_if #(
  parameter int COORD_WIDTH = segc_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_a_start_x;
  logic signed [COORD_WIDTH-1:0] seg_a_start_y;
  logic signed [COORD_WIDTH-1:0] seg_a_end_x;
  logic signed [COORD_WIDTH-1:0] seg_a_end_y;
  logic signed [COORD_WIDTH-1:0] seg_b_start_x;
  logic signed [COORD_WIDTH-1:0] seg_b_start_y;
  logic signed [COORD_WIDTH-1:0] seg_b_end_x;
  logic signed [COORD_WIDTH-1:0] seg_b_end_y;
  logic        [COORD_WIDTH-2:0] margin;

  modport source (
    output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y, margin,
    input  ready
  );

  modport sink (
    input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y, margin,
    output ready
  );
endinterface

### src/segc_result_if.sv
`timescale 1ns / 1ps

interface segc_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

### src/segment_crossing_test_top.sv
`timescale 1ns / 1ps

// K = ceil((COORD_WIDTH+2)/16), from the width of the grown box bounds.
// Throughput: one query per cycle; every stage holds under back-pressure.
// K is the number of 16-bit digit stages in each of the two multiplier layers.
// Reset clears only the per-stage valid bits; datapath registers are not reset.
module segment_crossing_test_top #(
  parameter int COORD_WIDTH = segc_pkg::DEF_COORD_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  segc_query_if.sink    query,
  segc_result_if.source result
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;          // coordinate differences
  localparam int BDW = W + 2;          // grown box bounds
  localparam int LW  = 2 * W + 3;      // line constants and determinant
  localparam int PW  = 3 * W + 5;      // numerators and bound products
  localparam int DIG = segc_pkg::MUL_DIGIT;
  localparam int K   = (BDW + DIG - 1) / DIG;
  localparam int N   = 5 + 2 * K;

  // Stage map
  localparam int S_IN   = 0;           // capture query
  localparam int S_PREP = 1;           // differences and grown boxes
  localparam int S_M1   = 2;           // first multiplier layer, K stages
  localparam int S_L1   = 2 + K;       // line constants and determinant
  localparam int S_M2   = 3 + K;       // second multiplier layer, K stages
  localparam int S_NUM  = 3 + 2 * K;   // intersection numerators
  localparam int S_OUT  = 4 + 2 * K;   // result register

  typedef struct packed {
    logic signed [DW-1:0]  la;
    logic signed [DW-1:0]  lb;
    logic signed [DW-1:0]  ld;
    logic signed [DW-1:0]  le;
    logic signed [BDW-1:0] alx;
    logic signed [BDW-1:0] ahx;
    logic signed [BDW-1:0] aly;
    logic signed [BDW-1:0] ahy;
    logic signed [BDW-1:0] blx;
    logic signed [BDW-1:0] bhx;
    logic signed [BDW-1:0] bly;
    logic signed [BDW-1:0] bhy;
  } side1_t;

  typedef struct packed {
    logic ovl;   // grown boxes overlap on both axes
    logic neg;   // determinant negative
    logic nz;    // determinant nonzero
  } side2_t;

  localparam int S1W = $bits(side1_t) + 1;
  localparam int S2W = $bits(side2_t);

  // Grown interval of two coordinates: [min - m, max + m]
  function automatic logic signed [BDW-1:0] grow_lo(
    input logic signed [W-1:0] p,
    input logic signed [W-1:0] q,
    input logic        [W-2:0] m
  );
    logic signed [BDW-1:0] mn;
    logic signed [BDW-1:0] ms;
    mn = (p < q) ? BDW'(p) : BDW'(q);
    ms = BDW'({1'b0, m});
    return mn - ms;
  endfunction

  function automatic logic signed [BDW-1:0] grow_hi(
    input logic signed [W-1:0] p,
    input logic signed [W-1:0] q,
    input logic        [W-2:0] m
  );
    logic signed [BDW-1:0] mx;
    logic signed [BDW-1:0] ms;
    mx = (p < q) ? BDW'(q) : BDW'(p);
    ms = BDW'({1'b0, m});
    return mx + ms;
  endfunction

  // lo*det <= n <= hi*det for positive det; the bounds swap roles when det is negative
  function automatic logic in_span(
    input logic signed [PW-1:0] plo,
    input logic signed [PW-1:0] phi,
    input logic signed [PW-1:0] n,
    input logic                 neg
  );
    logic r;
    if (neg) begin
      r = (phi <= n) && (n <= plo);
    end else begin
      r = (plo <= n) && (n <= phi);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake and per-stage load enables
  // ---------------------------------------------------------------------------
  logic [N-1:0] load;

  segc_ctrl #(.N(N)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .load      (load)
  );

  // ---------------------------------------------------------------------------
  // Capture the query beat
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic        [W-2:0] mg;

  always_ff @(posedge clk) begin
    if (load[S_IN]) begin
      ax0 <= query.seg_a_start_x;
      ay0 <= query.seg_a_start_y;
      ax1 <= query.seg_a_end_x;
      ay1 <= query.seg_a_end_y;
      bx0 <= query.seg_b_start_x;
      by0 <= query.seg_b_start_y;
      bx1 <= query.seg_b_end_x;
      by1 <= query.seg_b_end_y;
      mg  <= query.margin;
    end
  end

  // ---------------------------------------------------------------------------
  // Line direction terms and grown bounding boxes
  // ---------------------------------------------------------------------------
  side1_t pre_next;
  side1_t pre;
  logic signed [W-1:0] c_ax0, c_ay0, c_ax1, c_ay1, c_bx0, c_by0, c_bx1, c_by1;

  always_comb begin
    pre_next.la  = DW'(ay0) - DW'(ay1);
    pre_next.lb  = DW'(ax1) - DW'(ax0);
    pre_next.ld  = DW'(by1) - DW'(by0);
    pre_next.le  = DW'(bx0) - DW'(bx1);
    pre_next.alx = grow_lo(ax0, ax1, mg);
    pre_next.ahx = grow_hi(ax0, ax1, mg);
    pre_next.aly = grow_lo(ay0, ay1, mg);
    pre_next.ahy = grow_hi(ay0, ay1, mg);
    pre_next.blx = grow_lo(bx1, bx0, mg);
    pre_next.bhx = grow_hi(bx1, bx0, mg);
    pre_next.bly = grow_lo(by1, by0, mg);
    pre_next.bhy = grow_hi(by1, by0, mg);
  end

  always_ff @(posedge clk) begin
    if (load[S_PREP]) begin
      pre   <= pre_next;
      c_ax0 <= ax0;
      c_ay0 <= ay0;
      c_ax1 <= ax1;
      c_ay1 <= ay1;
      c_bx0 <= bx0;
      c_by0 <= by0;
      c_bx1 <= bx1;
      c_by1 <= by1;
    end
  end

  // ---------------------------------------------------------------------------
  // First multiplier layer: line constants and determinant products
  // ---------------------------------------------------------------------------
  logic signed [LW-1:0] p_ax1ay0, p_ay1ax0, p_bx0by1, p_by0bx1, p_lbld, p_lale;

  segc_mul #(.AW(DW), .BW(BDW)) u_m_ax1ay0 (
    .clk (clk), .en (load[S_M1 +: K]),
    .a (DW'(c_ax1)), .b (BDW'(c_ay0)), .p (p_ax1ay0)
  );

  segc_mul #(.AW(DW), .BW(BDW)) u_m_ay1ax0 (
    .clk (clk), .en (load[S_M1 +: K]),
    .a (DW'(c_ay1)), .b (BDW'(c_ax0)), .p (p_ay1ax0)
  );

  segc_mul #(.AW(DW), .BW(BDW)) u_m_bx0by1 (
    .clk (clk), .en (load[S_M1 +: K]),
    .a (DW'(c_bx0)), .b (BDW'(c_by1)), .p (p_bx0by1)
  );

  segc_mul #(.AW(DW), .BW(BDW)) u_m_by0bx1 (
    .clk (clk), .en (load[S_M1 +: K]),
    .a (DW'(c_by0)), .b (BDW'(c_bx1)), .p (p_by0bx1)
  );

  segc_mul #(.AW(DW), .BW(BDW)) u_m_lbld (
    .clk (clk), .en (load[S_M1 +: K]),
    .a (pre.lb), .b (BDW'(pre.ld)), .p (p_lbld)
  );

  segc_mul #(.AW(DW), .BW(BDW)) u_m_lale (
    .clk (clk), .en (load[S_M1 +: K]),
    .a (pre.la), .b (BDW'(pre.le)), .p (p_lale)
  );

  // Box overlap on y and on x; carry it and the box bounds beside the products
  logic           ovl;
  logic [S1W-1:0] s1_q;

  assign ovl = (pre.ahy >= pre.bly) && (pre.bhy >= pre.aly) &&
               (pre.ahx >= pre.blx) && (pre.bhx >= pre.alx);

  segc_dly #(.WIDTH(S1W), .DEPTH(K)) u_dly1 (
    .clk (clk),
    .en  (load[S_M1 +: K]),
    .d   ({ovl, pre}),
    .q   (s1_q)
  );

  // ---------------------------------------------------------------------------
  // Line constants c, f and the determinant; all fit LW bits exactly
  // ---------------------------------------------------------------------------
  logic signed [LW-1:0] lc, lf, det;
  side1_t               l1;
  logic                 l1_ovl;

  always_ff @(posedge clk) begin
    if (load[S_L1]) begin
      lc           <= p_ax1ay0 - p_ay1ax0;
      lf           <= p_bx0by1 - p_by0bx1;
      det          <= p_lbld - p_lale;
      {l1_ovl, l1} <= s1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Second multiplier layer: numerators and every bound scaled by det
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]  p_lblf, p_lcle, p_lcld, p_lalf;
  logic signed [BDW-1:0] bnd [8];
  logic signed [PW-1:0]  bp  [8];

  segc_mul #(.AW(LW), .BW(BDW)) u_m_lblf (
    .clk (clk), .en (load[S_M2 +: K]),
    .a (lf), .b (BDW'(l1.lb)), .p (p_lblf)
  );

  segc_mul #(.AW(LW), .BW(BDW)) u_m_lcle (
    .clk (clk), .en (load[S_M2 +: K]),
    .a (lc), .b (BDW'(l1.le)), .p (p_lcle)
  );

  segc_mul #(.AW(LW), .BW(BDW)) u_m_lcld (
    .clk (clk), .en (load[S_M2 +: K]),
    .a (lc), .b (BDW'(l1.ld)), .p (p_lcld)
  );

  segc_mul #(.AW(LW), .BW(BDW)) u_m_lalf (
    .clk (clk), .en (load[S_M2 +: K]),
    .a (lf), .b (BDW'(l1.la)), .p (p_lalf)
  );

  // Bound order: A x lo/hi, A y lo/hi, B x lo/hi, B y lo/hi
  assign bnd[0] = l1.alx;
  assign bnd[1] = l1.ahx;
  assign bnd[2] = l1.aly;
  assign bnd[3] = l1.ahy;
  assign bnd[4] = l1.blx;
  assign bnd[5] = l1.bhx;
  assign bnd[6] = l1.bly;
  assign bnd[7] = l1.bhy;

  for (genvar i = 0; i < 8; i++) begin : g_bmul
    segc_mul #(.AW(LW), .BW(BDW)) u_m_bnd (
      .clk (clk), .en (load[S_M2 +: K]),
      .a (det), .b (bnd[i]), .p (bp[i])
    );
  end

  side2_t         s2_in;
  logic [S2W-1:0] s2_q;

  always_comb begin
    s2_in.ovl = l1_ovl;
    s2_in.neg = det[LW-1];
    s2_in.nz  = |det;
  end

  segc_dly #(.WIDTH(S2W), .DEPTH(K)) u_dly2 (
    .clk (clk),
    .en  (load[S_M2 +: K]),
    .d   (s2_in),
    .q   (s2_q)
  );

  // ---------------------------------------------------------------------------
  // Intersection numerators; hold the scaled bounds alongside
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] nx, ny;
  logic signed [PW-1:0] bq [8];
  side2_t               n_side;

  always_ff @(posedge clk) begin
    if (load[S_NUM]) begin
      nx     <= p_lblf - p_lcle;
      ny     <= p_lcld - p_lalf;
      n_side <= s2_q;
      for (int i = 0; i < 8; i++) begin
        bq[i] <= bp[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final verdict: boxes overlap, lines not parallel, point inside both boxes
  // ---------------------------------------------------------------------------
  logic hit_next;
  logic hit;

  assign hit_next = n_side.ovl && n_side.nz &&
                    in_span(bq[0], bq[1], nx, n_side.neg) &&
                    in_span(bq[2], bq[3], ny, n_side.neg) &&
                    in_span(bq[4], bq[5], nx, n_side.neg) &&
                    in_span(bq[6], bq[7], ny, n_side.neg);

  always_ff @(posedge clk) begin
    if (load[S_OUT]) begin
      hit <= hit_next;
    end
  end

  assign result.hit = hit;

endmodule

### src/segc_ctrl.sv
`timescale 1ns / 1ps

module segc_ctrl #(
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [N-1:0] load
);

  logic [N-1:0] v;
  logic [N-1:0] v_in;
  logic [N:0]   rdy;

  assign rdy[N] = out_ready;

  // A stage takes a new beat when it is empty or its content moves on
  for (genvar s = 0; s < N; s++) begin : g_rdy
    assign rdy[s] = ~v[s] | rdy[s+1];
  end

  assign v_in      = {v[N-2:0], in_valid};
  assign load      = rdy[N-1:0] & v_in;
  // Refuse beats while reset is held so none is dropped
  assign in_ready  = rdy[0] & ~rst;
  assign out_valid = v[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~rdy[N-1:0]) | (v_in & rdy[N-1:0]);
    end
  end

endmodule

### src/segc_dly.sv
`timescale 1ns / 1ps

module segc_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic [DEPTH-1:0] en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap [DEPTH];

  // Advance each tap only when its pipeline stage loads
  for (genvar i = 0; i < DEPTH; i++) begin : g_tap
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[i]) begin
          tap[i] <= d;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[i]) begin
          tap[i] <= tap[i-1];
        end
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

### src/segc_mul.sv
`timescale 1ns / 1ps

module segc_mul #(
  parameter int AW = 33,
  parameter int BW = 34,
  localparam int DIG = segc_pkg::MUL_DIGIT,
  localparam int K   = (BW + DIG - 1) / DIG,
  localparam int PW  = AW + BW
) (
  input  logic                 clk,
  input  logic [K-1:0]         en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [PW-1:0] p
);

  localparam int BXW = K * DIG;
  localparam int XW  = PW + DIG + 1;

  logic signed [AW-1:0]  a_q   [K];
  logic signed [BXW-1:0] b_q   [K];
  logic signed [PW-1:0]  acc_q [K];

  // One digit of b per stage: low digits unsigned, top digit carries the sign
  for (genvar j = 0; j < K; j++) begin : g_stage
    logic signed [AW-1:0]  a_j;
    logic signed [BXW-1:0] b_j;
    logic signed [PW-1:0]  acc_j;
    logic [DIG-1:0]        dg;
    logic signed [DIG:0]   ds;
    logic signed [AW+DIG:0] pp;
    logic signed [XW-1:0]  pp_x;

    if (j == 0) begin : g_head
      assign a_j   = a;
      assign b_j   = BXW'(b);
      assign acc_j = '0;
    end else begin : g_body
      assign a_j   = a_q[j-1];
      assign b_j   = b_q[j-1];
      assign acc_j = acc_q[j-1];
    end

    assign dg = b_j[j*DIG +: DIG];

    if (j == K - 1) begin : g_top
      assign ds = {dg[DIG-1], dg};
    end else begin : g_low
      assign ds = {1'b0, dg};
    end

    assign pp   = a_j * ds;
    assign pp_x = XW'(pp) <<< (j * DIG);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        a_q[j]   <= a_j;
        b_q[j]   <= b_j;
        acc_q[j] <= acc_j + pp_x[PW-1:0];
      end
    end
  end

  assign p = acc_q[K-1];

endmodule
